[design/fpt_pkg.sv]
package fpt_pkg;

  localparam int MaxFrameRate = 128;
  localparam int IdxW = $clog2(MaxFrameRate);
  localparam int RateW = IdxW + 1;
  localparam int TimeW = 44;

  localparam logic [0:0] CfgFrameRate = 1'b0;
  localparam logic [0:0] CfgTestEnable = 1'b1;
  localparam logic OpFrame = 1'b0;
  localparam logic OpResync = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StPrep,
    StUpdate,
    StSumFrame,
    StDivFrame,
    StSumCap,
    StDivCap,
    StCapFps,
    StCapFpsDiv,
    StFps,
    StFpsDiv,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic update;
    logic sum_clear;
    logic sum_frame_step;
    logic sum_cap_step;
    logic div_start_frame;
    logic div_start_cap;
    logic div_start_fps;
    logic div_start_capfps;
    logic avg_take;
    logic cap_take;
    logic fps_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_resync;
    logic last_of_window;
    logic do_capacity;
    logic idx_zero;
    logic sum_done;
    logic div_busy;
    logic avg_nonzero;
  } stat_t;

endpackage

[design/fpt_div.sv]
module fpt_div import fpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [50:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [50:0] quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [50:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q[31:0], quot_q[50]};
    if (start_i) begin
      cnt_d = 6'd51;
      quot_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[49:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[49:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule

[design/fpt_ctrl.sv]
module fpt_ctrl import fpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StPrep;
      StPrep: state_d = StUpdate;
      StUpdate: begin
        if (!stat_i.div_busy) begin
          if (stat_i.is_resync) begin
            state_d = stat_i.idx_zero ? StDone : StSumFrame;
          end else if (stat_i.last_of_window) begin
            state_d = StSumFrame;
          end else begin
            state_d = StFps;
          end
        end
      end
      StSumFrame: if (stat_i.sum_done) state_d = StDivFrame;
      StDivFrame: begin
        if (!stat_i.div_busy) begin
          if (stat_i.is_resync) state_d = StDone;
          else if (stat_i.do_capacity) state_d = StSumCap;
          else state_d = StFps;
        end
      end
      StSumCap: if (stat_i.sum_done) state_d = StDivCap;
      StDivCap: if (!stat_i.div_busy) state_d = StCapFps;
      StCapFps: state_d = StCapFpsDiv;
      StCapFpsDiv: if (!stat_i.div_busy) state_d = StFps;
      StFps: state_d = StFpsDiv;
      StFpsDiv: if (!stat_i.div_busy) state_d = StDone;
      StDone: if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: cmd_o.load = in_valid_i;
      StPrep: cmd_o.prep = 1'b1;
      StUpdate: begin
        cmd_o.update = !stat_i.div_busy;
        cmd_o.sum_clear = 1'b1;
      end
      StSumFrame: begin
        cmd_o.sum_frame_step = 1'b1;
        cmd_o.div_start_frame = stat_i.sum_done;
      end
      StDivFrame: begin
        cmd_o.avg_take = !stat_i.div_busy;
        cmd_o.sum_clear = !stat_i.div_busy;
      end
      StSumCap: begin
        cmd_o.sum_cap_step = 1'b1;
        cmd_o.div_start_cap = stat_i.sum_done;
      end
      StCapFps: cmd_o.div_start_capfps = 1'b1;
      StCapFpsDiv: cmd_o.cap_take = !stat_i.div_busy;
      StFps: cmd_o.div_start_fps = 1'b1;
      StFpsDiv: cmd_o.fps_take = !stat_i.div_busy;
      StDone: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[design/fpt_datapath.sv]
module fpt_datapath import fpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_sel_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               operation_i,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        after_wait_ms_i,
  output logic signed [42:0] wait_us_o,
  output logic [6:0]         frame_index_o,
  output logic [31:0]        average_frame_us_o,
  output logic [27:0]        fps_q8_o,
  output logic [21:0]        capacity_fps_q8_o,
  output logic [31:0]        total_game_ms_o,
  output logic [31:0]        total_real_ms_o
);

  logic [RateW-1:0] rate_q;
  logic             test_en_q;
  logic [IdxW-1:0]  idx_q;
  logic signed [TimeW-1:0] base_q, last_q, last_real_q, cap_last_q;
  logic [31:0] last_ms_q, last_real_ms_q;
  logic [31:0] avg_q;
  logic [27:0] fps_q;
  logic [21:0] cap_q;
  logic [31:0] game_q, real_q;

  logic             op_q;
  logic signed [TimeW-1:0] cur_q, after_q;
  logic [31:0]      cur_ms_q;
  logic [IdxW-1:0]  cidx_q;
  logic signed [TimeW-1:0] dur_q, cdur_q;
  logic signed [42:0] wait_q;

  logic [31:0] fring [MaxFrameRate];
  logic [31:0] cring [MaxFrameRate];
  logic [31:0] rd_q;
  logic [RateW-1:0] sptr_q;
  logic             rd_vld_q;
  logic [RateW-1:0] scount_q;
  logic [39:0]      sum_q;

  logic             div_start, div_busy;
  logic [50:0]      div_num, div_quot;
  logic [31:0]      div_den;

  logic [31:0] o_avg_q, o_game_q, o_real_q;
  logic [27:0] o_fps_q;
  logic [21:0] o_cap_q;
  logic [6:0]  o_idx_q;
  logic signed [42:0] o_wait_q;

  logic [IdxW-1:0] idx_eff;
  logic            last_win;
  logic [21:0]     cap_lim;
  logic [39:0]     cap_sum;
  logic [7:0]      cfg_rate;

  function automatic logic [31:0] clamp32(input logic signed [TimeW-1:0] d);
    if (d < 0) return '0;
    if (d > $signed({{(TimeW-32){1'b0}}, 32'hFFFF_FFFF})) return 32'hFFFF_FFFF;
    return d[31:0];
  endfunction

  assign idx_eff = ({1'b0, idx_q} >= rate_q) ? '0 : idx_q;
  assign last_win = ({1'b0, idx_eff} == rate_q - RateW'(1));
  assign cap_lim = 22'(rate_q) * 22'(25600);
  assign cfg_rate = (cfg_data_i == 8'd0) ? 8'd0 :
                    (cfg_data_i > 8'(MaxFrameRate)) ? 8'(MaxFrameRate) : cfg_data_i;

  assign stat_o.is_resync = op_q;
  assign stat_o.last_of_window = last_win;
  assign stat_o.do_capacity = test_en_q;
  assign stat_o.idx_zero = (idx_eff == '0);
  assign stat_o.sum_done = !rd_vld_q && (sptr_q == scount_q);
  assign stat_o.div_busy = div_busy;
  assign stat_o.avg_nonzero = (avg_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      cur_ms_q <= now_ms_i;
      cur_q <= $signed({12'd0, now_ms_i}) * $signed(TimeW'(1000));
      after_q <= $signed({12'd0, after_wait_ms_i}) * $signed(TimeW'(1000));
    end
    if (cmd_i.prep) begin
      cidx_q <= idx_eff;
      dur_q <= cur_q - last_q;
      cdur_q <= cur_q - cap_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !op_q) begin
      fring[cidx_q] <= clamp32(dur_q);
      if (test_en_q) cring[cidx_q] <= clamp32(cdur_q);
    end
    rd_q <= cmd_i.sum_cap_step ? cring[sptr_q[IdxW-1:0]] : fring[sptr_q[IdxW-1:0]];
  end

  assign cap_sum = (sum_q == '0) ? 40'd10000 : sum_q;

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = {24'd0, rate_q};
    if (cmd_i.div_start_frame || cmd_i.div_start_cap) begin
      div_start = 1'b1;
      div_num = {11'd0, (cmd_i.div_start_cap ? cap_sum : sum_q)};
      div_den = {{(32-RateW){1'b0}}, (op_q ? {1'b0, cidx_q} : rate_q)};
    end else if (cmd_i.div_start_capfps) begin
      div_start = 1'b1;
      div_num = 51'd256000000;
      div_den = div_quot[31:0];
    end else if (cmd_i.div_start_fps) begin
      div_start = 1'b1;
      div_num = 51'd256000000;
      div_den = avg_q;
    end else if (cmd_i.prep) begin
      div_start = 1'b1;
      div_num = 51'd1000000;
      div_den = {24'd0, rate_q};
    end
  end

  fpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateW'(60);
      test_en_q <= 1'b0;
      idx_q <= '0;
      base_q <= '0;
      last_q <= '0;
      last_real_q <= '0;
      last_ms_q <= '0;
      last_real_ms_q <= '0;
      cap_last_q <= '0;
      avg_q <= '0;
      fps_q <= '0;
      cap_q <= '0;
      game_q <= '0;
      real_q <= '0;
      sptr_q <= '0;
      rd_vld_q <= 1'b0;
      scount_q <= '0;
      sum_q <= '0;
      wait_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_sel_i == CfgFrameRate) begin
          if (cfg_rate != 8'd0) begin
            rate_q <= RateW'(cfg_rate);
            idx_q <= '0;
          end
        end else begin
          test_en_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.update) begin
        if (op_q) begin
          last_q <= cur_q;
          last_ms_q <= cur_ms_q;
          cap_last_q <= cur_q;
          base_q <= cur_q - TimeW'(1000000) + $signed({24'd0, div_quot[19:0]});
          wait_q <= '0;
          scount_q <= {1'b0, cidx_q};
          idx_q <= '0;
        end else begin
          game_q <= game_q + (cur_ms_q - last_ms_q);
          real_q <= real_q + (cur_ms_q - last_real_ms_q);
          if (cidx_q == '0) begin
            if (last_q == '0) wait_q <= $signed({23'd0, div_quot[19:0]});
            else wait_q <= 43'(base_q + TimeW'(1000000) - cur_q);
            base_q <= cur_q + $signed({24'd0, div_quot[19:0]});
          end else begin
            wait_q <= 43'(base_q + $signed({24'd0, div_quot[19:0]} * {37'd0, cidx_q})
                          - cur_q);
          end
          last_q <= cur_q;
          last_real_q <= cur_q;
          last_ms_q <= cur_ms_q;
          last_real_ms_q <= cur_ms_q;
          if (test_en_q) cap_last_q <= after_q;
          scount_q <= rate_q;
          idx_q <= last_win ? '0 : cidx_q + IdxW'(1);
        end
      end
      if (cmd_i.sum_clear) begin
        sum_q <= '0;
        sptr_q <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.sum_frame_step || cmd_i.sum_cap_step) begin
        if (rd_vld_q) sum_q <= sum_q + {8'd0, rd_q};
        rd_vld_q <= (sptr_q < scount_q);
        if (sptr_q < scount_q) sptr_q <= sptr_q + RateW'(1);
      end
      if (cmd_i.avg_take) avg_q <= div_quot[31:0];
      if (cmd_i.cap_take) begin
        cap_q <= (div_quot > {29'd0, cap_lim}) ? cap_lim : div_quot[21:0];
      end
      if (cmd_i.fps_take) fps_q <= (avg_q == '0) ? '0 : div_quot[27:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_wait_q <= wait_q;
      o_idx_q <= 7'(idx_q);
      o_avg_q <= avg_q;
      o_fps_q <= fps_q;
      o_cap_q <= cap_q;
      o_game_q <= game_q;
      o_real_q <= real_q;
    end
  end

  assign wait_us_o = o_wait_q;
  assign frame_index_o = o_idx_q;
  assign average_frame_us_o = o_avg_q;
  assign fps_q8_o = o_fps_q;
  assign capacity_fps_q8_o = o_cap_q;
  assign total_game_ms_o = o_game_q;
  assign total_real_ms_o = o_real_q;

endmodule

[design/frame_pacing_timer.sv]
// Channel | Direction | Signals
// input   | in        | in_valid_i, in_ready_o, operation_i, now_ms_i, after_wait_ms_i
// result  | out       | out_valid_o, out_ready_i, wait_us_o .. total_real_ms_o
// config  | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// One request is handled at a time.
// The 51-step divider and the ring summing loop (one entry a cycle) set how long a request takes.
// Reset clears all control state; the duration rings hold no reset value.
// A waiting result holds the block in its last state until it is taken.
module frame_pacing_timer import fpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        after_wait_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [42:0] wait_us_o,
  output logic [6:0]         frame_index_o,
  output logic [31:0]        average_frame_us_o,
  output logic [27:0]        fps_q8_o,
  output logic [21:0]        capacity_fps_q8_o,
  output logic [31:0]        total_game_ms_o,
  output logic [31:0]        total_real_ms_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  fpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fpt_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_valid_i),
    .cfg_sel_i          (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .now_ms_i           (now_ms_i),
    .after_wait_ms_i    (after_wait_ms_i),
    .wait_us_o          (wait_us_o),
    .frame_index_o      (frame_index_o),
    .average_frame_us_o (average_frame_us_o),
    .fps_q8_o           (fps_q8_o),
    .capacity_fps_q8_o  (capacity_fps_q8_o),
    .total_game_ms_o    (total_game_ms_o),
    .total_real_ms_o    (total_real_ms_o)
  );

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_ready_o |-> !(cmd.load))
    else $error("input taken while busy");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(wait_us_o))
    else $error("result changed while stalled");

  a_single_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.div_start_frame, cmd.div_start_cap, cmd.div_start_fps,
              cmd.div_start_capfps}))
    else $error("divider started twice");

endmodule

[test/fpt_checker.sv]
`timescale 1ns / 1ps

module fpt_checker import fpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic               operation_i,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        after_wait_ms_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic signed [42:0] wait_us_o,
  input  logic [6:0]         frame_index_o,
  input  logic [31:0]        average_frame_us_o,
  input  logic [27:0]        fps_q8_o,
  input  logic [21:0]        capacity_fps_q8_o,
  input  logic [31:0]        total_game_ms_o,
  input  logic [31:0]        total_real_ms_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    logic signed [42:0] wait_us;
    logic [6:0]         frame_index;
    logic [31:0]        average_us;
    logic [27:0]        fps_q8;
    logic [21:0]        capacity_q8;
    logic [31:0]        game_ms;
    logic [31:0]        real_ms;
  } pacing_result_t;

  pacing_result_t slot_q[$];

  logic [31:0] dur_ring[MaxFrameRate];
  logic [31:0] cap_ring[MaxFrameRate];
  int unsigned win_idx;
  longint      base_us, last_us, last_real_us, cap_last_us;
  logic [31:0] avg_us;
  logic [27:0] fps_val;
  logic [21:0] cap_val;
  logic [31:0] game_total, real_total;
  int unsigned rate;
  logic        test_en;

  function automatic logic [31:0] clamp_dur(longint d);
    if (d < 0) return 32'd0;
    if (d > 64'sh0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return d[31:0];
  endfunction

  task automatic schedule_frame(logic op, logic [31:0] now_ms, logic [31:0] after_ms);
    longint cur, after, per, wt, gms, rms, s, cap, a, c;
    int unsigned i, k;
    bit last_w;
    pacing_result_t r;
    cur = longint'(now_ms) * 1000;
    after = longint'(after_ms) * 1000;
    per = 1000000 / rate;
    wt = 0;
    if (win_idx >= rate) win_idx = 0;
    if (op == OpResync) begin
      last_us = cur;
      cap_last_us = cur;
      base_us = cur - (1000000 - per);
      if (win_idx > 0) begin
        s = 0;
        for (i = 0; i < win_idx; i++) s += longint'(dur_ring[i]);
        avg_us = 32'(s / win_idx);
      end
      win_idx = 0;
    end else begin
      k = win_idx;
      last_w = (k == rate - 1);
      gms = (cur - last_us) / 1000;
      rms = (cur - last_real_us) / 1000;
      game_total += gms[31:0];
      real_total += rms[31:0];
      if (k == 0) begin
        wt = (last_us == 0) ? per : base_us + 1000000 - cur;
        base_us = cur + per;
      end else begin
        wt = base_us + per * k - cur;
      end
      dur_ring[k] = clamp_dur(cur - last_us);
      last_us = cur;
      last_real_us = cur;
      if (last_w) begin
        s = 0;
        for (i = 0; i < rate; i++) s += longint'(dur_ring[i]);
        avg_us = 32'(s / rate);
      end
      if (test_en) begin
        cap_ring[k] = clamp_dur(cur - cap_last_us);
        if (last_w) begin
          s = 0;
          for (i = 0; i < rate; i++) s += longint'(cap_ring[i]);
          cap = 100 * rate * 256;
          if (s == 0) s = 10000;
          a = s / rate;
          c = (a == 0) ? cap : 256000000 / a;
          if (c > cap) c = cap;
          cap_val = c[21:0];
        end
        cap_last_us = after;
      end
      win_idx = (k + 1) % rate;
      fps_val = (avg_us > 0) ? 28'(256000000 / longint'(avg_us)) : 28'd0;
    end
    r.wait_us = wt[42:0];
    r.frame_index = win_idx[6:0];
    r.average_us = avg_us;
    r.fps_q8 = fps_val;
    r.capacity_q8 = cap_val;
    r.game_ms = game_total;
    r.real_ms = real_total;
    slot_q.push_back(r);
  endtask

  task automatic field_check(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pacing_result_t e;
    if (!rst_ni) begin
      slot_q.delete();
      win_idx = 0;
      base_us = 0;
      last_us = 0;
      last_real_us = 0;
      cap_last_us = 0;
      avg_us = '0;
      fps_val = '0;
      cap_val = '0;
      game_total = '0;
      real_total = '0;
      rate = 60;
      test_en = 1'b0;
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (slot_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request pending, wait_us %0d", $time, wait_us_o);
        end else begin
          e = slot_q.pop_front();
          field_check("wait_us", e.wait_us, wait_us_o);
          field_check("frame_index", e.frame_index, frame_index_o);
          field_check("average_frame_us", e.average_us, average_frame_us_o);
          field_check("fps_q8", e.fps_q8, fps_q8_o);
          field_check("capacity_fps_q8", e.capacity_q8, capacity_fps_q8_o);
          field_check("total_game_ms", e.game_ms, total_game_ms_o);
          field_check("total_real_ms", e.real_ms, total_real_ms_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgFrameRate) begin
          if (cfg_data_i != 0) begin
            rate = (cfg_data_i > MaxFrameRate) ? MaxFrameRate : cfg_data_i;
            win_idx = 0;
          end
        end else begin
          test_en = cfg_data_i[0];
        end
      end
      if (in_valid_i && in_ready_o) schedule_frame(operation_i, now_ms_i, after_wait_ms_i);
      pending_count = slot_q.size();
    end
  end

endmodule

[test/tb_frame_pacing_timer.sv]
`timescale 1ns / 1ps

module tb_frame_pacing_timer;
  import fpt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = OpFrame;
  logic [31:0] now_ms_i = '0;
  logic [31:0] after_wait_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [42:0] wait_us_o;
  logic [6:0] frame_index_o;
  logic [31:0] average_frame_us_o;
  logic [27:0] fps_q8_o;
  logic [21:0] capacity_fps_q8_o;
  logic [31:0] total_game_ms_o;
  logic [31:0] total_real_ms_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = CfgFrameRate;
  logic [7:0] cfg_data_i = '0;
  int fail_count, pending_count;
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  always #6 clk_i = ~clk_i;

  frame_pacing_timer uut (.*);
  fpt_checker checker_i (.*);

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(logic op, logic [31:0] now_ms, logic [31:0] after_ms);
    in_valid_i <= 1'b1;
    operation_i <= op;
    now_ms_i <= now_ms;
    after_wait_ms_i <= after_ms;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic paced_frame(int unsigned rate);
    int unsigned per_ms, r;
    logic [31:0] now_ms, after_ms;
    per_ms = (rate > 1000) ? 1 : 1000 / rate;
    r = $urandom_range(0, 99);
    if (r < 6) now_ms = $urandom();
    else now_ms = clock_ms + per_ms + $urandom_range(0, 4) - 2;
    if ($urandom_range(0, 9) == 0) after_ms = $urandom();
    else after_ms = now_ms + $urandom_range(0, per_ms);
    clock_ms = now_ms;
    send_request((r >= 6 && r < 10) ? OpResync : OpFrame, now_ms, after_ms);
  endtask

  initial begin
    int unsigned rates[9] = '{1, 2, 3, 128, 7, 255, 17, 5, 60};
    int unsigned eff;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(OpFrame, 32'd5, 32'd5);
    send_request(OpFrame, 32'd0, 32'd0);
    send_request(OpFrame, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OpFrame, 32'd0, 32'hFFFF_FFFF);
    send_request(OpResync, 32'd100, 32'd0);
    send_request(OpResync, 32'hFFFF_FFFF, 32'd0);
    send_request(OpFrame, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(OpResync, 32'd0, 32'd0);
    drain();
    write_reg(CfgTestEnable, 8'd1);
    write_reg(CfgFrameRate, 8'd2);
    for (int i = 0; i < 4; i++) send_request(OpFrame, 32'd7000, 32'd7000);
    for (int i = 0; i < 4; i++) send_request(OpFrame, 32'd7000 + i, 32'd7000 + i);
    send_request(OpFrame, 32'd9000, 32'd8000);
    send_request(OpResync, 32'd9500, 32'd0);
    send_request(OpFrame, 32'hFFFF_FFFF, 32'd0);
    send_request(OpFrame, 32'hFFFF_FFFF, 32'd0);
    drain();

    for (int p = 0; p < 9; p++) begin
      eff = (rates[p] > MaxFrameRate) ? MaxFrameRate : rates[p];
      quiet = (p == 8);
      write_reg(CfgTestEnable, 8'($urandom_range(0, 3)));
      if (p == 4) write_reg(CfgFrameRate, 8'd0);
      write_reg(CfgFrameRate, 8'(rates[p]));
      for (int i = 0; i < ((eff >= 60) ? eff + 10 : 2 * eff + 30); i++) paced_frame(eff);
      drain();
    end

    repeat (500) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
